@@ rtl/core/hhbw_pkg.sv @@
package hhbw_pkg;

    typedef struct packed {
        logic [8:0] x_start;
        logic [8:0] x_end;
        logic [7:0] row;
        logic [7:0] fill_mode;
    } t_span;

    typedef struct packed {
        logic [15:0] byte_address;
        logic [7:0]  bit_mask;
        logic [7:0]  mode_out;
        logic        last_write;
    } t_write;

    typedef enum logic [1:0] {
        COL_LO,
        COL_CUR,
        COL_HI
    } t_col_sel;

    typedef enum logic [1:0] {
        MASK_FULL,
        MASK_FIRST,
        MASK_LAST,
        MASK_BOTH
    } t_mask_sel;

    // Commands from the sequencer to the datapath.
    typedef struct packed {
        logic      load;
        logic      c_init;
        logic      c_inc;
        logic      sel_odd;
        t_col_sel  col;
        t_mask_sel mask;
        logic      last;
    } t_dp_cmd;

    // Span status from the datapath to the sequencer.
    typedef struct packed {
        logic single;
        logic a_odd;
        logic b_odd;
        logic same_col;
        logic inner_first;
        logic inner_more;
    } t_dp_stat;

    localparam int unsigned APB_AW = 3;

    localparam logic REG_EVEN_PAGE = 1'b0;
    localparam logic REG_ODD_PAGE  = 1'b1;

    localparam logic [7:0] EVEN_PAGE_RST = 8'd64;
    localparam logic [7:0] ODD_PAGE_RST  = 8'd96;

endpackage

@@ rtl/core/hhbw_dp.sv @@
module hhbw_dp
    import hhbw_pkg::*;
(
    input  logic     i_clk,
    input  t_span    i_span,
    input  t_dp_cmd  i_cmd,
    input  logic [7:0] i_even_page,
    input  logic [7:0] i_odd_page,
    output t_dp_stat o_stat,
    output t_write   o_write
);

    logic [8:0] r_lo;
    logic [8:0] r_hi;
    logic [7:0] r_row;
    logic [7:0] r_mode;
    logic [4:0] r_col;

    logic [4:0] col_lo;
    logic [4:0] col_hi;
    logic [4:0] col;
    logic [7:0] page;
    logic [7:0] mask_first;
    logic [7:0] mask_last;
    logic [7:0] mask;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            if (i_span.x_start > i_span.x_end) begin
                r_lo <= i_span.x_end;
                r_hi <= i_span.x_start;
            end else begin
                r_lo <= i_span.x_start;
                r_hi <= i_span.x_end;
            end
            r_row  <= i_span.row;
            r_mode <= i_span.fill_mode;
        end
        if (i_cmd.c_init) begin
            r_col <= r_lo[8:4] + 5'd1;
        end else if (i_cmd.c_inc) begin
            r_col <= r_col + 5'd1;
        end
    end

    assign col_lo = r_lo[8:4];
    assign col_hi = r_hi[8:4];

    assign o_stat.single      = (r_lo[8:3] == r_hi[8:3]);
    assign o_stat.a_odd       = r_lo[3];
    assign o_stat.b_odd       = r_hi[3];
    assign o_stat.same_col    = (col_lo == col_hi);
    assign o_stat.inner_first = (({1'b0, col_lo} + 6'd1) < {1'b0, col_hi});
    assign o_stat.inner_more  = (({1'b0, r_col} + 6'd1) < {1'b0, col_hi});

    assign mask_first = 8'hff >> r_lo[2:0];
    assign mask_last  = 8'hff << (3'd7 - r_hi[2:0]);

    always_comb begin
        case (i_cmd.col)
            COL_LO:  col = col_lo;
            COL_CUR: col = r_col;
            COL_HI:  col = col_hi;
            default: col = col_lo;
        endcase
        case (i_cmd.mask)
            MASK_FULL:  mask = 8'hff;
            MASK_FIRST: mask = mask_first;
            MASK_LAST:  mask = mask_last;
            MASK_BOTH:  mask = mask_first & mask_last;
            default:    mask = 8'hff;
        endcase
    end

    assign page = i_cmd.sel_odd ? i_odd_page : i_even_page;

    // The bank bits land at 4..3 and the line bits at 2..0 of the high byte;
    // the character row sits above the 5-bit column in the low byte.
    assign o_write.byte_address = {page | {3'b000, r_row[7:6], r_row[2:0]}, r_row[5:3], col};
    assign o_write.bit_mask     = mask;
    assign o_write.mode_out     = r_mode;
    assign o_write.last_write   = i_cmd.last;

endmodule

@@ rtl/core/hhbw_ctrl.sv @@
module hhbw_ctrl
    import hhbw_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    input  logic     i_out_stall,
    input  t_dp_stat i_stat,
    output logic     o_in_stall,
    output logic     o_out_valid,
    output t_dp_cmd  o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_SETUP,
        S_SINGLE,
        S_F0,
        S_F1,
        S_IE,
        S_IO,
        S_L0,
        S_L1
    } t_state;

    t_state r_state;
    t_state n_state;
    t_state last_col_state;
    logic   r_valid;
    logic   r_busy;
    logic   n_valid;
    logic   adv;

    assign adv = r_valid & ~i_out_stall;

    // The final column opens with a full even byte only when the span ends
    // in an odd byte and began in an earlier column.
    assign last_col_state = (i_stat.b_odd && !i_stat.same_col) ? S_L0 : S_L1;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_SETUP;
                end
            end
            S_SETUP: begin
                if (i_stat.single) begin
                    n_state = S_SINGLE;
                end else if (!i_stat.a_odd && !i_stat.same_col) begin
                    n_state = S_F0;
                end else begin
                    n_state = S_F1;
                end
            end
            S_SINGLE: begin
                o_cmd.sel_odd = i_stat.a_odd;
                o_cmd.col     = COL_LO;
                o_cmd.mask    = MASK_BOTH;
                o_cmd.last    = 1'b1;
                if (adv) begin
                    n_state = S_IDLE;
                end
            end
            S_F0: begin
                o_cmd.sel_odd = 1'b1;
                o_cmd.col     = COL_LO;
                o_cmd.mask    = MASK_FULL;
                if (adv) begin
                    n_state = S_F1;
                end
            end
            S_F1: begin
                o_cmd.sel_odd = i_stat.a_odd;
                o_cmd.col     = COL_LO;
                o_cmd.mask    = MASK_FIRST;
                if (adv) begin
                    if (i_stat.inner_first) begin
                        o_cmd.c_init = 1'b1;
                        n_state      = S_IE;
                    end else begin
                        n_state = last_col_state;
                    end
                end
            end
            S_IE: begin
                o_cmd.sel_odd = 1'b0;
                o_cmd.col     = COL_CUR;
                o_cmd.mask    = MASK_FULL;
                if (adv) begin
                    n_state = S_IO;
                end
            end
            S_IO: begin
                o_cmd.sel_odd = 1'b1;
                o_cmd.col     = COL_CUR;
                o_cmd.mask    = MASK_FULL;
                if (adv) begin
                    if (i_stat.inner_more) begin
                        o_cmd.c_inc = 1'b1;
                        n_state     = S_IE;
                    end else begin
                        n_state = last_col_state;
                    end
                end
            end
            S_L0: begin
                o_cmd.sel_odd = 1'b0;
                o_cmd.col     = COL_HI;
                o_cmd.mask    = MASK_FULL;
                if (adv) begin
                    n_state = S_L1;
                end
            end
            S_L1: begin
                o_cmd.sel_odd = i_stat.b_odd;
                o_cmd.col     = COL_HI;
                o_cmd.mask    = MASK_LAST;
                o_cmd.last    = 1'b1;
                if (adv) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign n_valid = (n_state != S_IDLE) && (n_state != S_SETUP);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
            r_busy  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
            r_busy  <= (n_state != S_IDLE);
        end
    end

    assign o_in_stall  = r_busy;
    assign o_out_valid = r_valid;

endmodule

@@ rtl/core/hires_hline_byte_writes.sv @@
// Horizontal span fill for a 512-pixel interleaved hi-res screen. Each accepted
// span transaction (two x ends in either order, a row and a fill mode) yields
// one to 64 masked byte write transactions, in order, the last one flagged by
// last_write. The block accepts a span and decodes its ends, then issues one
// write per cycle while the output side does not stall, from a single sequencer
// and output mux. The input stalls until the last write of the span has been
// taken. The even and odd screen pages are APB registers at byte addresses 0
// and 4 (reset 64 and 96) and should be written only while no span is in
// flight.
module hires_hline_byte_writes
    import hhbw_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  t_span             i_in,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output t_write            o_out,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    logic [7:0] r_even_page;
    logic [7:0] r_odd_page;
    logic       cfg_wr;
    logic       reg_sel;
    t_dp_cmd    cmd;
    t_dp_stat   stat;

    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite;
    assign reg_sel = paddr[2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_even_page <= EVEN_PAGE_RST;
            r_odd_page  <= ODD_PAGE_RST;
        end else if (cfg_wr) begin
            case (reg_sel)
                REG_EVEN_PAGE: r_even_page <= pwdata[7:0];
                REG_ODD_PAGE:  r_odd_page  <= pwdata[7:0];
                default:       r_even_page <= r_even_page;
            endcase
        end
    end

    always_comb begin
        case (reg_sel)
            REG_EVEN_PAGE: prdata = {24'd0, r_even_page};
            REG_ODD_PAGE:  prdata = {24'd0, r_odd_page};
            default:       prdata = 32'd0;
        endcase
    end

    hhbw_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_out_stall (i_out_stall),
        .i_stat      (stat),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_cmd       (cmd)
    );

    hhbw_dp u_dp (
        .i_clk       (i_clk),
        .i_span      (i_in),
        .i_cmd       (cmd),
        .i_even_page (r_even_page),
        .i_odd_page  (r_odd_page),
        .o_stat      (stat),
        .o_write     (o_out)
    );

    // No write is offered while the block is free to take a new span.
    a_idle_no_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_stall |-> !o_out_valid)
        else $error("write offered while block is idle");

    // A newly accepted span is decoded in the setup state before its first write is offered.
    a_setup_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> (o_in_stall && !o_out_valid))
        else $error("no decode cycle after span accepted");

    // Taking the flagged last write ends the span.
    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_stall && o_out.last_write) |=> !o_out_valid)
        else $error("write offered after last write of span");

    // Every write covers at least one pixel.
    a_mask_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out.bit_mask != 8'd0))
        else $error("empty bit mask");

endmodule

@@ verif/span_write_checker.sv @@
module span_write_checker
    import hhbw_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_stall,
    input  t_span             i_in,
    input  logic              i_out_valid,
    input  logic              i_out_stall,
    input  t_write            i_out,
    input  logic              i_psel,
    input  logic              i_penable,
    input  logic              i_pwrite,
    input  logic [APB_AW-1:0] i_paddr,
    input  logic [31:0]       i_pwdata,
    input  logic              i_pready,
    output int                o_fail_count,
    output int                o_pending,
    output int                o_writes_seen
);

    logic [7:0] even_page;
    logic [7:0] odd_page;
    t_write     pending_writes[$];
    int         fail_count;
    int         writes_seen;

    function automatic void queue_write(logic [7:0] addr_hi, logic [7:0] addr_lo,
                                        logic [7:0] mask, logic [7:0] mode);
        t_write w;
        w.byte_address = {addr_hi, addr_lo};
        w.bit_mask     = mask;
        w.mode_out     = mode;
        w.last_write   = 1'b0;
        pending_writes.push_back(w);
    endfunction

    // Expands one span into its byte writes, in the order the screen is walked.
    function automatic void expand_span(t_span s);
        logic [8:0] left_x;
        logic [8:0] right_x;
        logic [7:0] line_hi;
        logic [7:0] even_hi;
        logic [7:0] odd_hi;
        logic [2:0] char_row;
        logic [4:0] col_left;
        logic [4:0] col_right;
        logic [7:0] left_mask;
        logic [7:0] right_mask;
        int         col;
        left_x  = (s.x_start > s.x_end) ? s.x_end : s.x_start;
        right_x = (s.x_start > s.x_end) ? s.x_start : s.x_end;
        line_hi = {3'b000, s.row[7:6], s.row[2:0]};
        even_hi = even_page | line_hi;
        odd_hi  = odd_page | line_hi;
        char_row   = s.row[5:3];
        col_left   = left_x[8:4];
        col_right  = right_x[8:4];
        left_mask  = 8'hff >> left_x[2:0];
        right_mask = 8'hff << (3'd7 - right_x[2:0]);

        if (left_x[8:3] == right_x[8:3]) begin
            queue_write(left_x[3] ? odd_hi : even_hi, {char_row, col_left},
                        left_mask & right_mask, s.fill_mode);
        end else begin
            if (left_x[3]) begin
                queue_write(odd_hi, {char_row, col_left}, left_mask, s.fill_mode);
            end else begin
                // The odd byte of the first column is full and goes out first.
                if (col_left != col_right)
                    queue_write(odd_hi, {char_row, col_left}, 8'hff, s.fill_mode);
                queue_write(even_hi, {char_row, col_left}, left_mask, s.fill_mode);
            end
            for (col = int'(col_left) + 1; col < int'(col_right); col++) begin
                queue_write(even_hi, {char_row, col[4:0]}, 8'hff, s.fill_mode);
                queue_write(odd_hi, {char_row, col[4:0]}, 8'hff, s.fill_mode);
            end
            if (right_x[3]) begin
                if (col_left != col_right)
                    queue_write(even_hi, {char_row, col_right}, 8'hff, s.fill_mode);
                queue_write(odd_hi, {char_row, col_right}, right_mask, s.fill_mode);
            end else begin
                queue_write(even_hi, {char_row, col_right}, right_mask, s.fill_mode);
            end
        end
        pending_writes[pending_writes.size() - 1].last_write = 1'b1;
    endfunction

    always @(posedge i_clk) begin : monitor
        t_write expected;
        if (!i_rst_n) begin
            even_page = EVEN_PAGE_RST;
            odd_page  = ODD_PAGE_RST;
            pending_writes.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                if (i_paddr == {REG_EVEN_PAGE, 2'b00})
                    even_page = i_pwdata[7:0];
                else if (i_paddr == {REG_ODD_PAGE, 2'b00})
                    odd_page = i_pwdata[7:0];
            end

            if (i_out_valid && !i_out_stall) begin
                writes_seen++;
                if (pending_writes.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected write transaction: addr %h mask %h",
                                 i_out.byte_address, i_out.bit_mask,
                                 " mode %h last %b", i_out.mode_out,
                                 i_out.last_write);
                end else begin
                    expected = pending_writes.pop_front();
                    if (i_out.byte_address !== expected.byte_address ||
                        i_out.bit_mask !== expected.bit_mask ||
                        i_out.mode_out !== expected.mode_out ||
                        i_out.last_write !== expected.last_write) begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("write mismatch: expected addr %h mask %h",
                                     expected.byte_address, expected.bit_mask,
                                     " mode %h last %b,", expected.mode_out,
                                     expected.last_write,
                                     " got addr %h mask %h", i_out.byte_address,
                                     i_out.bit_mask,
                                     " mode %h last %b", i_out.mode_out,
                                     i_out.last_write);
                    end
                end
            end

            if (i_in_valid && !i_in_stall)
                expand_span(i_in);
        end
        o_pending     <= pending_writes.size();
        o_fail_count  <= fail_count;
        o_writes_seen <= writes_seen;
    end

endmodule

@@ verif/hires_hline_byte_writes_test.sv @@
module hires_hline_byte_writes_test;
    import hhbw_pkg::*;

    localparam int HOLD_CYCLES = 400;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_in_valid;
    logic              o_in_stall;
    t_span             i_in;
    logic              o_out_valid;
    logic              i_out_stall;
    t_write            o_out;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [31:0]       pwdata;
    logic [31:0]       prdata;
    logic              pready;

    int fail_count;
    int pending;
    int writes_seen;
    int spans_sent;
    int tx_idle_pct;
    int rx_idle_pct;
    int hold_requests;
    int holds_served;

    hires_hline_byte_writes dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    span_write_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .i_in_stall    (o_in_stall),
        .i_in          (i_in),
        .i_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .i_out         (o_out),
        .i_psel        (psel),
        .i_penable     (penable),
        .i_pwrite      (pwrite),
        .i_paddr       (paddr),
        .i_pwdata      (pwdata),
        .i_pready      (pready),
        .o_fail_count  (fail_count),
        .o_pending     (pending),
        .o_writes_seen (writes_seen)
    );

    initial i_clk = 1'b0;
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    initial begin
        #6000000;
        $display("Simulation FAILED");
        $finish;
    end

    // Output side: random stalls, plus a long hold whenever one is requested.
    initial begin
        i_out_stall = 1'b0;
        forever begin
            @(posedge i_clk);
            if (holds_served != hold_requests) begin
                holds_served++;
                i_out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            i_out_stall <= ($urandom_range(99) < rx_idle_pct);
        end
    end

    function automatic t_span span_of(logic [8:0] xs, logic [8:0] xe,
                                      logic [7:0] row, logic [7:0] mode);
        t_span s;
        s.x_start   = xs;
        s.x_end     = xe;
        s.row       = row;
        s.fill_mode = mode;
        return s;
    endfunction

    task automatic send_span(t_span s);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in       <= s;
        i_in_valid <= 1'b1;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        spans_sent++;
    endtask

    // Stops offering spans until every predicted write has been taken.
    task automatic drain_writes();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_page(logic reg_idx, logic [7:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_idx, 2'b00};
        pwdata  <= {24'h0, value};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic random_spans(int count, int tx_pct, int rx_pct, int hold_at);
        int         kind;
        int         far_x;
        logic [8:0] xs;
        logic [8:0] xe;
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        for (int n = 0; n < count; n++) begin
            if (n == hold_at)
                hold_requests <= hold_requests + 1;
            kind = $urandom_range(9);
            if (kind < 5) begin
                xs = 9'($urandom_range(511));
                xe = 9'($urandom_range(511));
            end else if (kind < 8) begin
                // Short spans stress the single-byte and column-edge cases.
                xs    = 9'($urandom_range(511));
                far_x = int'(xs) + $urandom_range(24);
                xe    = (far_x > 511) ? 9'd511 : far_x[8:0];
                if ($urandom_range(1)) begin
                    far_x = int'(xs);
                    xs    = xe;
                    xe    = far_x[8:0];
                end
            end else begin
                xs = 9'($urandom_range(63) * 8 + ($urandom_range(1) ? 7 : 0));
                xe = 9'($urandom_range(63) * 8 + ($urandom_range(1) ? 7 : 0));
            end
            send_span(span_of(xs, xe, 8'($urandom_range(255)), 8'($urandom_range(255))));
        end
    endtask

    initial begin
        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_in          = '0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        spans_sent    = 0;
        hold_requests = 0;
        holds_served  = 0;
        tx_idle_pct   = 13;
        rx_idle_pct   = 46;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed spans with the reset page values.
        send_span(span_of(9'd0, 9'd511, 8'h00, 8'h00));
        send_span(span_of(9'd511, 9'd0, 8'hff, 8'hff));
        send_span(span_of(9'd3, 9'd5, 8'h38, 8'h01));
        send_span(span_of(9'd14, 9'd9, 8'hc0, 8'h02));
        send_span(span_of(9'd0, 9'd0, 8'h07, 8'h03));
        send_span(span_of(9'd511, 9'd511, 8'h80, 8'h04));
        send_span(span_of(9'd2, 9'd37, 8'h41, 8'h05));
        send_span(span_of(9'd10, 9'd60, 8'h12, 8'h06));
        send_span(span_of(9'd4, 9'd12, 8'h23, 8'h07));
        send_span(span_of(9'd4, 9'd28, 8'h34, 8'h08));
        send_span(span_of(9'd12, 9'd35, 8'h45, 8'h09));
        send_span(span_of(9'd15, 9'd16, 8'h56, 8'h0a));
        send_span(span_of(9'd7, 9'd8, 8'h67, 8'h0b));
        send_span(span_of(9'd8, 9'd15, 8'h78, 8'h0c));
        send_span(span_of(9'd0, 9'd7, 8'h89, 8'h0d));
        send_span(span_of(9'd0, 9'd15, 8'h9a, 8'h0e));
        send_span(span_of(9'd496, 9'd511, 8'hab, 8'h0f));
        send_span(span_of(9'd256, 9'd255, 8'hbc, 8'h10));
        send_span(span_of(9'd100, 9'd400, 8'hff, 8'haa));
        send_span(span_of(9'd255, 9'd256, 8'h3f, 8'h55));
        drain_writes();

        write_page(REG_EVEN_PAGE, 8'h00);
        write_page(REG_ODD_PAGE, 8'hff);
        random_spans(100, 13, 46, 30);
        drain_writes();

        write_page(REG_EVEN_PAGE, 8'hff);
        write_page(REG_ODD_PAGE, 8'h00);
        random_spans(100, 46, 13, -1);
        drain_writes();

        write_page(REG_EVEN_PAGE, 8'($urandom_range(255)));
        write_page(REG_ODD_PAGE, 8'($urandom_range(255)));
        random_spans(100, 0, 0, 50);
        drain_writes();

        write_page(REG_EVEN_PAGE, 8'($urandom_range(255)));
        write_page(REG_ODD_PAGE, 8'($urandom_range(255)));
        random_spans(108, 0, 0, -1);
        drain_writes();
        repeat (10) @(posedge i_clk);

        $display("Ran %0d span transactions into %0d byte write transactions",
                 spans_sent, writes_seen, " over five page settings,");
        $display("with random idling on both channels and %0d output holds of %0d cycles.",
                 holds_served, HOLD_CYCLES);
        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

@@ hires_hline_byte_writes.f @@
rtl/core/hhbw_pkg.sv
rtl/core/hhbw_dp.sv
rtl/core/hhbw_ctrl.sv
rtl/core/hires_hline_byte_writes.sv
verif/span_write_checker.sv
verif/hires_hline_byte_writes_test.sv
